@@ hdl/lppg_pkg.sv @@
// shared types, mode codes and brightness table for the led pattern pwm generator
`timescale 1ns / 1ps

package lppg_pkg;

  typedef logic [2:0]  mode_t;
  typedef logic [6:0]  percent_t;
  typedef logic [9:0]  pwm_t;
  typedef logic [31:0] ms_t;

  // pattern mode codes
  localparam mode_t MODE_OFF     = 3'd0;
  localparam mode_t MODE_ON      = 3'd1;
  localparam mode_t MODE_FLASH   = 3'd2;
  localparam mode_t MODE_TOGGLE  = 3'd3;
  localparam mode_t MODE_BREATHE = 3'd4;

  // timing constants in milliseconds
  localparam ms_t FLASH_ON_MS   = 32'd50;
  localparam ms_t FLASH_OFF_MS  = 32'd2000;
  localparam ms_t TOGGLE_MS     = 32'd100;
  localparam ms_t INHALE_MS     = 32'd2000;
  localparam ms_t EXHALE_MS     = 32'd2500;
  localparam ms_t HOLD_MS       = 32'd1200;
  localparam ms_t BREATH_CYCLE_MS = INHALE_MS + EXHALE_MS + HOLD_MS;

  localparam percent_t FULL_PERCENT = 7'd100;
  localparam percent_t BREATH_FLOOR = 7'd10;
  localparam pwm_t     PWM_MAX      = 10'd1023;

  // pattern state carried between items
  typedef struct packed {
    percent_t level;
    ms_t      last_change;
  } lppg_state_t;

  // floor(2^(p/10)) - 1 for p = 0..100
  localparam pwm_t EXP_TABLE [0:100] = '{
    10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,
    10'd1,   10'd1,   10'd1,   10'd1,   10'd1,   10'd1,   10'd2,   10'd2,   10'd2,   10'd2,
    10'd3,   10'd3,   10'd3,   10'd3,   10'd4,   10'd4,   10'd5,   10'd5,   10'd5,   10'd6,
    10'd7,   10'd7,   10'd8,   10'd8,   10'd9,   10'd10,  10'd11,  10'd11,  10'd12,  10'd13,
    10'd15,  10'd16,  10'd17,  10'd18,  10'd20,  10'd21,  10'd23,  10'd24,  10'd26,  10'd28,
    10'd31,  10'd33,  10'd35,  10'd38,  10'd41,  10'd44,  10'd47,  10'd50,  10'd54,  10'd58,
    10'd63,  10'd67,  10'd72,  10'd77,  10'd83,  10'd89,  10'd96,  10'd102, 10'd110, 10'd118,
    10'd127, 10'd136, 10'd146, 10'd156, 10'd167, 10'd180, 10'd193, 10'd206, 10'd221, 10'd237,
    10'd255, 10'd273, 10'd293, 10'd314, 10'd336, 10'd361, 10'd387, 10'd414, 10'd444, 10'd476,
    10'd511, 10'd547, 10'd587, 10'd629, 10'd674, 10'd723, 10'd775, 10'd830, 10'd890, 10'd954,
    10'd1023
  };

endpackage

@@ hdl/led_pattern_pwm_generator_top.sv @@
// top level of the led pattern pwm generator
`timescale 1ns / 1ps

// led pattern pwm generator
// - input channel (in_valid / in_ready / in_now_ms): one transfer per millisecond
//   time sample; each accepted sample yields exactly one result
// - result channel (out_valid / out_ready): out_pwm_level is the active-low pwm
//   value (1023 = dark), out_brightness_percent the linear level 0..100
// - cfg_wr_en / cfg_wr_data set the pattern mode (0 off, 1 on, 2 flash,
//   3 toggle, 4 breathing); a changed mode clears level and timestamp
// - a transferred sample lands in the input register, then the pattern step
//   fills the result register
// - throughput: one sample per cycle while out_ready holds; the pattern state is
//   updated in the same cycle that a sample moves into the result register, so
//   the next sample sees it straight away
// - when the receiver stalls the result register holds and the input register
//   still takes one more sample; after that in_ready drops until out_ready
// - reset (rst_n low, synchronous) empties both stages, sets mode off and
//   clears level and timestamp
module led_pattern_pwm_generator_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lppg_pkg::ms_t       in_now_ms,
  output logic                out_valid,
  input  logic                out_ready,
  output lppg_pkg::pwm_t      out_pwm_level,
  output lppg_pkg::percent_t  out_brightness_percent,
  input  logic                cfg_wr_en,
  input  lppg_pkg::mode_t     cfg_wr_data
);
  import lppg_pkg::*;

  // input register
  logic        in_vld_r;
  ms_t         now_r;
  // result register
  logic        out_vld_r;
  pwm_t        pwm_r;
  percent_t    pct_r;
  // pattern state and mode
  mode_t       mode_r;
  lppg_state_t state_r;
  lppg_state_t state_nxt;
  pwm_t        pwm_nxt;

  logic        advance;
  logic        in_xfer;

  // sample moves on when the result register is empty or being drained
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;
  assign in_xfer  = in_valid && in_ready;

  lppg_step u_step (
    .mode      (mode_r),
    .state_cur (state_r),
    .now_ms    (now_r),
    .state_nxt (state_nxt),
    .pwm_level (pwm_nxt)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      now_r <= in_now_ms;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pwm_r <= pwm_nxt;
      pct_r <= state_nxt.level;
    end
  end

  // mode and pattern state; the user must write the mode only while idle, the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_OFF;
      state_r <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_wr_data != mode_r) begin
        mode_r  <= cfg_wr_data;
        state_r <= '0;
      end
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  assign out_valid              = out_vld_r;
  assign out_pwm_level          = pwm_r;
  assign out_brightness_percent = pct_r;

endmodule

@@ hdl/lppg_step.sv @@
// next pattern state and pwm level for one time sample
`timescale 1ns / 1ps

module lppg_step (
  input  lppg_pkg::mode_t       mode,
  input  lppg_pkg::lppg_state_t state_cur,
  input  lppg_pkg::ms_t         now_ms,
  output lppg_pkg::lppg_state_t state_nxt,
  output lppg_pkg::pwm_t        pwm_level
);
  import lppg_pkg::*;

  ms_t         elapsed;
  ms_t         breath_t;
  logic        breath_wrap;
  logic [11:0] up_x;
  logic [17:0] up_prod;
  percent_t    up_level;
  logic [12:0] dn_u;
  logic [11:0] dn_x;
  logic [22:0] dn_prod;
  percent_t    dn_level;
  percent_t    breath_level;
  percent_t    level_raw;
  percent_t    level_sat;
  ms_t         last_nxt;

  assign elapsed     = now_ms - state_cur.last_change;
  assign breath_wrap = (elapsed > BREATH_CYCLE_MS);
  assign breath_t    = breath_wrap ? 32'd0 : elapsed;

  // ramp up: (t + 10) / 20, done as ((t + 10) >> 2) * 205 >> 10
  assign up_x     = {1'b0, breath_t[10:0]} + 12'd10;
  assign up_prod  = {8'd0, up_x[11:2]} * 18'd205;
  assign up_level = up_prod[16:10];

  // ramp down: 100 - (t - 2000 + 12) / 25, division as * 1311 >> 15
  assign dn_u     = breath_t[12:0] - INHALE_MS[12:0];
  assign dn_x     = dn_u[11:0] + 12'd12;
  assign dn_prod  = {11'd0, dn_x} * 23'd1311;
  assign dn_level = FULL_PERCENT - dn_prod[21:15];

  always_comb begin
    if (breath_t < INHALE_MS) begin
      breath_level = up_level;
    end else if (breath_t < INHALE_MS + EXHALE_MS) begin
      breath_level = dn_level;
    end else begin
      breath_level = state_cur.level;
    end
    if (breath_level < BREATH_FLOOR) begin
      breath_level = BREATH_FLOOR;
    end
  end

  always_comb begin
    level_raw = state_cur.level;
    last_nxt  = state_cur.last_change;
    case (mode)
      MODE_OFF: begin
        level_raw = 7'd0;
      end
      MODE_ON: begin
        level_raw = FULL_PERCENT;
      end
      MODE_FLASH: begin
        if (state_cur.level == FULL_PERCENT) begin
          if (elapsed > FLASH_ON_MS) begin
            level_raw = 7'd0;
            last_nxt  = now_ms;
          end
        end else if (elapsed > FLASH_OFF_MS) begin
          level_raw = FULL_PERCENT;
          last_nxt  = now_ms;
        end
      end
      MODE_TOGGLE: begin
        if (elapsed >= TOGGLE_MS) begin
          level_raw = (state_cur.level == 7'd0) ? FULL_PERCENT : 7'd0;
          last_nxt  = now_ms;
        end
      end
      MODE_BREATHE: begin
        level_raw = breath_level;
        if (breath_wrap) begin
          last_nxt = now_ms;
        end
      end
      default: begin
        level_raw = state_cur.level;
      end
    endcase
  end

  assign level_sat = (level_raw > FULL_PERCENT) ? FULL_PERCENT : level_raw;
  assign state_nxt = {level_sat, last_nxt};
  assign pwm_level = PWM_MAX - EXP_TABLE[level_sat];

endmodule
